### rtl/core/sobel_edge_rgb_stream_unit_defines.svh
// Assertion macros shared by the checker files of the Sobel edge unit.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SOBEL_EDGE_RGB_STREAM_UNIT_DEFINES_SVH
`define SOBEL_EDGE_RGB_STREAM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SERS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SERS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### rtl/core/sers_pkg.sv
package sers_pkg;

    // Stream geometry
    localparam int NUM_CHAN        = 3;
    localparam int PIX_W           = 8;
    localparam int MAX_WIDTH       = 1920;
    localparam int LB_ADDR_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W         = 11;
    localparam int HEIGHT_W        = 16;

    // Gradient of one channel: |gx| + |gy| reaches 2040.
    localparam int GRAD_W          = 11;
    localparam int EDGE_MAX        = 255;

    // Each pixel leaves as three identical bytes.
    localparam int BEATS_PER_PIXEL = 3;
    localparam int BEAT_W          = 2;

    // Configuration channel
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int FRAME_WIDTH_RST  = 1920;
    localparam int FRAME_HEIGHT_RST = 1080;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]     byte_t;
    typedef byte_t [NUM_CHAN-1:0] pix_t;
    typedef logic [LB_ADDR_W-1:0] lb_addr_t;
    typedef logic [GRAD_W-1:0]    grad_t;
    typedef grad_t [NUM_CHAN-1:0] grad_vec_t;

    // One line store word: the two previous rows at one column, all channels.
    typedef struct packed {
        pix_t older;
        pix_t prev;
    } lb_word_t;

    typedef struct packed {
        logic     en;
        lb_addr_t addr;
    } lb_rd_t;

    typedef struct packed {
        logic     en;
        lb_addr_t addr;
        lb_word_t data;
    } lb_wr_t;

    // Control that travels with a pixel down the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

### rtl/core/sers_if.sv
// Pixel input channel: one beat carries the three channel bytes of a pixel.
interface sers_pix_if;
    import sers_pkg::*;

    logic  valid;
    logic  ready;
    byte_t chan0;
    byte_t chan1;
    byte_t chan2;

    modport source (output valid, output chan0, output chan1, output chan2, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

// Result channel: one beat carries one output byte.
interface sers_res_if;
    import sers_pkg::*;

    logic  valid;
    logic  ready;
    byte_t edge_value;
    logic  frame_end;

    modport source (output valid, output edge_value, output frame_end, input ready);
    modport sink   (input valid, input edge_value, input frame_end, output ready);
endinterface

// Register write channel.
interface sers_cfg_if;
    import sers_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/sers_line_buf.sv
module sers_line_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  sers_pkg::lb_rd_t  rd,
    input  sers_pkg::lb_wr_t  wr,
    output sers_pkg::lb_word_t rd_word,
    output logic              busy
);
    import sers_pkg::*;

    lb_word_t mem [MAX_WIDTH];
    lb_word_t rd_data_reg;
    lb_word_t fwd_data_reg;
    logic     fwd_reg;
    logic     busy_reg;
    lb_addr_t clr_addr_reg;
    logic     mem_we;
    lb_addr_t mem_waddr;
    lb_word_t mem_wdata;

    // The clearing pass owns the write port until every column is zero.
    always_comb
    begin
        mem_we    = busy_reg | wr.en;
        mem_waddr = busy_reg ? clr_addr_reg : wr.addr;
        mem_wdata = busy_reg ? '0 : wr.data;
    end

    // Single write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
        if (rd.en)
        begin
            fwd_data_reg <= wr.data;
        end
    end

    // A read at the column written on the same edge takes the new word instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd.en)
        begin
            fwd_reg <= wr.en && (wr.addr == rd.addr);
        end
    end

    // Clearing pass after reset, one column per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == LB_ADDR_W'(MAX_WIDTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign rd_word = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign busy    = busy_reg;

endmodule

### rtl/core/sers_lane.sv
module sers_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  sers_pkg::byte_t older,
    input  sers_pkg::byte_t prev,
    input  sers_pkg::byte_t pix,
    output sers_pkg::grad_t grad
);
    import sers_pkg::*;

    byte_t      col0_reg [3];
    byte_t      col1_reg [3];
    byte_t      cur [3];
    logic [9:0] gx_pos;
    logic [9:0] gx_neg;
    logic [9:0] gy_pos;
    logic [9:0] gy_neg;
    logic [9:0] gx_abs;
    logic [9:0] gy_abs;
    grad_t      grad_reg;
    grad_t      grad_next;

    // Newest column of the window: top row is the oldest line.
    always_comb
    begin
        cur[0] = older;
        cur[1] = prev;
        cur[2] = pix;
    end

    // Sobel kernels, split into positive and negative halves.
    always_comb
    begin
        gx_pos = {2'b00, cur[0]} + {1'b0, cur[1], 1'b0} + {2'b00, cur[2]};
        gx_neg = {2'b00, col0_reg[0]} + {1'b0, col0_reg[1], 1'b0} + {2'b00, col0_reg[2]};
        gy_pos = {2'b00, col0_reg[0]} + {1'b0, col1_reg[0], 1'b0} + {2'b00, cur[0]};
        gy_neg = {2'b00, col0_reg[2]} + {1'b0, col1_reg[2], 1'b0} + {2'b00, cur[2]};
        gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
        gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
        grad_next = {1'b0, gx_abs} + {1'b0, gy_abs};
    end

    // Window shifts left by one column as each pixel passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                col0_reg[r] <= '0;
                col1_reg[r] <= '0;
            end
        end
        else if (shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                col0_reg[r] <= col1_reg[r];
                col1_reg[r] <= cur[r];
            end
        end
    end

    // Gradient register of this lane.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            grad_reg <= grad_next;
        end
    end

    assign grad = grad_reg;

endmodule

### rtl/core/sers_merge_out.sv
module sers_merge_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sers_pkg::stage_ctl_t s2,
    input  sers_pkg::grad_vec_t  grad,
    output logic                 take,
    sers_res_if.source           result
);
    import sers_pkg::*;

    logic [GRAD_W+1:0]   sum;
    logic [GRAD_W-1:0]   quot;
    byte_t               sat;
    logic                ob_valid_reg;
    byte_t               value_reg;
    logic                last_reg;
    logic [BEAT_W-1:0]   beat_reg;
    logic                out_fire;
    logic                final_beat;

    // Weighted channel merge, truncating divide by four, clamp to a byte.
    always_comb
    begin
        sum  = {1'b0, grad[0], 1'b0} + {2'b00, grad[1]} + {2'b00, grad[2]};
        quot = sum[GRAD_W+1:2];
        sat  = (quot > GRAD_W'(EDGE_MAX)) ? byte_t'(EDGE_MAX) : quot[PIX_W-1:0];
    end

    assign out_fire   = result.valid && result.ready;
    assign final_beat = (beat_reg == BEAT_W'(BEATS_PER_PIXEL - 1));
    assign take       = s2.valid && (!ob_valid_reg || (out_fire && final_beat));

    // Output buffer repeats the merged byte for each beat of the pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            beat_reg     <= '0;
        end
        else if (take)
        begin
            ob_valid_reg <= 1'b1;
            beat_reg     <= '0;
        end
        else if (out_fire)
        begin
            if (final_beat)
            begin
                ob_valid_reg <= 1'b0;
            end
            else
            begin
                beat_reg <= beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= sat;
            last_reg  <= s2.last;
        end
    end

    assign result.valid      = ob_valid_reg;
    assign result.edge_value = value_reg;
    assign result.frame_end  = last_reg && final_beat;

endmodule

### rtl/core/sobel_edge_rgb_stream_unit.sv
// Sobel edge detector for a raster stream of three-channel pixels. Each pixel beat on
// pixel yields three identical bytes on result, the combined |gx|+|gy| of the three
// channels weighted 2:1:1, divided by four and clamped to 255; frame_end marks the third
// byte of the last pixel of a frame. A pixel is taken in any cycle in which the pipeline
// can move; the first byte of its result is offered once the pixel has passed stage one,
// stage two and the output buffer. The result channel moves one byte per beat, so the
// output port sets the sustained rate. After reset the line store is cleared, one column
// per cycle, over all 1920 columns; pixel stays not ready until then, while register
// writes are taken at once. Registers: index 0 frame_width, index 1 frame_height; a zero
// acts as one. Edges of the frame use whatever the stores hold.
module sobel_edge_rgb_stream_unit (
    input  logic       clk,
    input  logic       rst_n,
    sers_pix_if.sink   pixel,
    sers_res_if.source result,
    sers_cfg_if.sink   cfg
);
    import sers_pkg::*;

    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [WIDTH_W-1:0]  col_reg;
    logic [WIDTH_W-1:0]  col_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;
    lb_addr_t            addr_reg;
    lb_addr_t            addr_next;
    logic [WIDTH_W-1:0]  width_m1;
    logic [HEIGHT_W-1:0] height_m1;
    logic                row_end;
    logic                frame_last;
    logic                in_fire;
    logic                lb_busy;
    stage_ctl_t          s1_reg;
    stage_ctl_t          s2_reg;
    pix_t                s1_pix_reg;
    lb_addr_t            s1_addr_reg;
    logic                s1_fire;
    logic                s2_take;
    lb_rd_t              lb_rd;
    lb_wr_t              lb_wr;
    lb_word_t            lb_word;
    grad_vec_t           grad;

    // Register writes; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_W'(FRAME_WIDTH_RST);
            frame_height_reg <= HEIGHT_W'(FRAME_HEIGHT_RST);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg.data[WIDTH_W-1:0];
            end
            else if (cfg.index == REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg.data[HEIGHT_W-1:0];
            end
        end
    end

    // Handshake through the pipeline stages.
    assign s1_fire     = s1_reg.valid && (!s2_reg.valid || s2_take);
    assign pixel.ready = !lb_busy && (!s1_reg.valid || s1_fire);
    assign in_fire     = pixel.valid && pixel.ready;

    // Raster position; the store column runs alongside and wraps at the store depth.
    always_comb
    begin
        width_m1   = (frame_width_reg == '0) ? '0 : frame_width_reg - 1'b1;
        height_m1  = (frame_height_reg == '0) ? '0 : frame_height_reg - 1'b1;
        row_end    = (col_reg >= width_m1);
        frame_last = row_end && (row_reg >= height_m1);
        col_next   = col_reg + 1'b1;
        row_next   = row_reg;
        addr_next  = (addr_reg == LB_ADDR_W'(MAX_WIDTH - 1)) ? '0 : addr_reg + 1'b1;
        if (frame_last)
        begin
            col_next  = '0;
            row_next  = '0;
            addr_next = '0;
        end
        else if (row_end)
        begin
            col_next  = '0;
            row_next  = row_reg + 1'b1;
            addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            addr_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            addr_reg <= addr_next;
        end
    end

    // Stage one: pixel waits for its line store word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (in_fire)
        begin
            s1_reg.valid <= 1'b1;
            s1_reg.last  <= frame_last;
        end
        else if (s1_fire)
        begin
            s1_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= {pixel.chan2, pixel.chan1, pixel.chan0};
            s1_addr_reg <= addr_reg;
        end
    end

    // Stage two: lane gradients are registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (s1_fire)
        begin
            s2_reg <= s1_reg;
        end
        else if (s2_take)
        begin
            s2_reg.valid <= 1'b0;
        end
    end

    // Line store: read at acceptance, write back the shifted rows as stage one leaves.
    always_comb
    begin
        lb_rd.en         = in_fire;
        lb_rd.addr       = addr_reg;
        lb_wr.en         = s1_fire;
        lb_wr.addr       = s1_addr_reg;
        lb_wr.data.older = lb_word.prev;
        lb_wr.data.prev  = s1_pix_reg;
    end

    sers_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (lb_rd),
        .wr      (lb_wr),
        .rd_word (lb_word),
        .busy    (lb_busy)
    );

    // One gradient lane per channel.
    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_lane
        sers_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (s1_fire),
            .older (lb_word.older[c]),
            .prev  (lb_word.prev[c]),
            .pix   (s1_pix_reg[c]),
            .grad  (grad[c])
        );
    end

    // Channel merge and byte serializer.
    sers_merge_out u_merge_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .s2     (s2_reg),
        .grad   (grad),
        .take   (s2_take),
        .result (result)
    );

endmodule

### rtl/core/sers_checker.sv
`include "sobel_edge_rgb_stream_unit_defines.svh"

module sers_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input sers_pkg::byte_t out_edge_value,
    input logic            out_frame_end
);
    import sers_pkg::*;

    logic              in_fire;
    logic              out_fire;
    logic [BEAT_W-1:0] beat_reg;
    logic [2:0]        pending_reg;
    byte_t             value_reg;
    logic              pixel_done;

    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_valid && out_ready;
    assign pixel_done = out_fire && (beat_reg == BEAT_W'(BEATS_PER_PIXEL - 1));

    // Track the beat position within a pixel and the pixels in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (out_fire)
            begin
                beat_reg <= pixel_done ? '0 : beat_reg + 1'b1;
            end
            pending_reg <= pending_reg + {2'b00, in_fire} - {2'b00, pixel_done};
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            value_reg <= out_edge_value;
        end
    end

    // A stalled result beat holds its payload.
    `SERS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_edge_value) && $stable(out_frame_end))

    // The frame end flag rides only on the third byte of a pixel.
    `SERS_ASSERT_NOW(a_end_on_third, out_valid && out_frame_end, beat_reg == BEAT_W'(BEATS_PER_PIXEL - 1))

    // All bytes of one pixel carry the same value.
    `SERS_ASSERT_NOW(a_same_bytes, out_valid && (beat_reg != '0), out_edge_value == value_reg)

    // At most three pixels are inside the pipeline at once.
    `SERS_ASSERT_NOW(a_in_flight, 1'b1, pending_reg <= 3'd3)

endmodule

bind sobel_edge_rgb_stream_unit sers_checker u_sers_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pixel.valid),
    .in_ready       (pixel.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_edge_value (result.edge_value),
    .out_frame_end  (result.frame_end)
);

### test/sers_edge_checker.sv
`timescale 1ns / 100ps

// Watches the pixel, result and register channels of the Sobel edge unit. It keeps its
// own line stores, window and raster counters, works out the three bytes every accepted
// pixel must produce and compares each result beat with the oldest one still due.
module sers_edge_checker (
    input  logic clk,
    input  logic rst_n,
    sers_pix_if  pixel,
    sers_res_if  result,
    sers_cfg_if  cfg,
    output int   fail_total,
    output int   beats_pending
);
    import sers_pkg::*;

    typedef struct packed {
        byte_t edge_value;
        logic  frame_end;
    } edge_beat_t;

    // Two previous rows per column and channel; index 0 holds the older row.
    byte_t      line_hist [2][MAX_WIDTH][NUM_CHAN];
    // Two older window columns per channel and row; index 1 is the newer column.
    byte_t      win_cols [NUM_CHAN][3][2];
    int         row_pos;
    int         col_pos;
    int         width_reg;
    int         height_reg;
    int         mismatches;
    int         beat_no;
    edge_beat_t edge_beats_due [$];

    // Prints one line about a failure and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] sers_edge_checker: beat %0d: %s", $realtime, beat_no, msg);
        mismatches++;
    endtask

    // Shifts one channel's stores and window by one pixel and returns |gx| + |gy|.
    function automatic int sobel_mag(input int ch, input int addr, input byte_t px);
        int    v [3][3];
        int    gx;
        int    gy;
        byte_t older;
        byte_t prev;
        older = line_hist[0][addr][ch];
        prev  = line_hist[1][addr][ch];
        line_hist[0][addr][ch] = prev;
        line_hist[1][addr][ch] = px;
        for (int r = 0; r < 3; r++)
        begin
            v[r][0] = win_cols[ch][r][0];
            v[r][1] = win_cols[ch][r][1];
        end
        v[0][2] = older;
        v[1][2] = prev;
        v[2][2] = px;
        for (int r = 0; r < 3; r++)
        begin
            win_cols[ch][r][0] = win_cols[ch][r][1];
            win_cols[ch][r][1] = byte_t'(v[r][2]);
        end
        gx = -v[0][0] + v[0][2] - 2 * v[1][0] + 2 * v[1][2] - v[2][0] + v[2][2];
        gy = v[0][0] + 2 * v[0][1] + v[0][2] - v[2][0] - 2 * v[2][1] - v[2][2];
        return (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int         addr;
        int         w;
        int         h;
        int         mix;
        logic       row_done;
        logic       frame_done;
        edge_beat_t due;
        edge_beat_t beat;
        if (!rst_n)
        begin
            // All stores come out of reset cleared.
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < MAX_WIDTH; j++)
                    for (int k = 0; k < NUM_CHAN; k++)
                        line_hist[i][j][k] = '0;
            for (int i = 0; i < NUM_CHAN; i++)
                for (int j = 0; j < 3; j++)
                begin
                    win_cols[i][j][0] = '0;
                    win_cols[i][j][1] = '0;
                end
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            mismatches = 0;
            beat_no    = 0;
            edge_beats_due.delete();
        end
        else
        begin
            // Register writes; unknown indexes are dropped.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FRAME_WIDTH:  width_reg  = int'(cfg.data[WIDTH_W-1:0]);
                    REG_FRAME_HEIGHT: height_reg = int'(cfg.data[HEIGHT_W-1:0]);
                    default: ;
                endcase
            end

            // Each accepted pixel queues three identical bytes.
            if (pixel.valid && pixel.ready)
            begin
                addr       = col_pos % MAX_WIDTH;
                w          = (width_reg == 0) ? 1 : width_reg;
                h          = (height_reg == 0) ? 1 : height_reg;
                row_done   = (col_pos >= w - 1);
                frame_done = row_done && (row_pos >= h - 1);
                mix        = 2 * sobel_mag(0, addr, pixel.chan0);
                mix        = mix + sobel_mag(1, addr, pixel.chan1);
                mix        = (mix + sobel_mag(2, addr, pixel.chan2)) / 4;
                if (mix > EDGE_MAX)
                    mix = EDGE_MAX;
                for (int k = 0; k < BEATS_PER_PIXEL; k++)
                begin
                    beat.edge_value = byte_t'(mix);
                    beat.frame_end  = frame_done && (k == BEATS_PER_PIXEL - 1);
                    edge_beats_due.push_back(beat);
                end
                if (frame_done)
                begin
                    col_pos = 0;
                    row_pos = 0;
                end
                else if (row_done)
                begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) & 'hFFFF;
                end
                else
                    col_pos = (col_pos + 1) & 'h7FF;
            end

            // Compare each result beat with the oldest byte still due.
            if (result.valid && result.ready)
            begin
                if (edge_beats_due.size() == 0)
                    report_mismatch($sformatf("unexpected beat, edge_value %0d frame_end %0b",
                                              result.edge_value, result.frame_end));
                else
                begin
                    due = edge_beats_due.pop_front();
                    if (result.edge_value !== due.edge_value)
                        report_mismatch($sformatf("edge_value %0d, predicted %0d",
                                                  result.edge_value, due.edge_value));
                    if (result.frame_end !== due.frame_end)
                        report_mismatch($sformatf("frame_end %0b, predicted %0b",
                                                  result.frame_end, due.frame_end));
                end
                beat_no++;
            end
        end
        fail_total    <= mismatches;
        beats_pending <= edge_beats_due.size();
    end

endmodule

### test/tb_sobel_edge_rgb_stream_unit.sv
`timescale 1ns / 100ps

// Drives pixels and register writes into the Sobel edge unit under several idling
// patterns and hands the checking to sers_edge_checker.
module tb_sobel_edge_rgb_stream_unit;
    import sers_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 50;
    localparam int WIDE_WIDTH    = 2047;

    // Register indexes that the block does not decode.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // Kinds of pixel content.
    localparam int STYLE_NOISE  = 0;
    localparam int STYLE_SMOOTH = 1;
    localparam int STYLE_RAILS  = 2;

    logic clk;
    logic rst_n;
    logic rx_hold;
    int   fail_total;
    int   beats_pending;
    int   cycle_count = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    event pressure_kick;

    sers_pix_if pix_if ();
    sers_res_if res_if ();
    sers_cfg_if cfg_if ();

    sobel_edge_rgb_stream_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    sers_edge_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pix_if),
        .result        (res_if),
        .cfg           (cfg_if),
        .fail_total    (fail_total),
        .beats_pending (beats_pending)
    );

    // 2 ns clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result receiver: random stalls, or a full hold-off while rx_hold is set.
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= rst_n && !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so that the pixel sender keeps offering.
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(pressure_kick);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // Writes one register; valid stays up when another write follows at once.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit more);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        if (!more)
            cfg_if.valid <= 1'b0;
    endtask

    task automatic write_geometry(input logic [CFG_DATA_W-1:0] w,
                                  input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w, 1'b1);
        write_reg(REG_FRAME_HEIGHT, h, 1'b0);
    endtask

    // Offers one pixel beat after a random number of idle cycles.
    task automatic send_pixel(input byte_t c0, input byte_t c1, input byte_t c2);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.chan0 <= c0;
        pix_if.chan1 <= c1;
        pix_if.chan2 <= c2;
        do @(posedge clk); while (!pix_if.ready);
    endtask

    // Stops offering pixels and waits until every predicted byte has come out.
    task automatic drain_pixels();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (beats_pending != 0);
    endtask

    task automatic next_pixel(input int style, input int base, input int amp,
                              output byte_t c0, output byte_t c1, output byte_t c2);
        case (style)
            STYLE_SMOOTH:
            begin
                c0 = byte_t'(base + $urandom_range(0, amp));
                c1 = byte_t'(base + $urandom_range(0, amp));
                c2 = byte_t'(base + $urandom_range(0, amp));
            end
            STYLE_RAILS:
            begin
                c0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                c1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                c2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
                c0 = byte_t'($urandom);
                c1 = byte_t'($urandom);
                c2 = byte_t'($urandom);
            end
        endcase
    endtask

    initial
    begin
        byte_t c0;
        byte_t c1;
        byte_t c2;
        int    w;
        int    h;
        int    style;
        int    amp;
        int    base;
        int    pick;

        rst_n        = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.chan0 = '0;
        pix_if.chan1 = '0;
        pix_if.chan2 = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Undecoded indexes must be ignored; then a 4x2 frame of rail values,
        // including a lone first channel that counts double.
        write_reg(REG_SPARE_A, 16'hFFFF, 1'b1);
        write_reg(REG_SPARE_B, 16'h0001, 1'b1);
        write_geometry(16'd4, 16'd2);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        drain_pixels();

        // Zero width and height act as one: every pixel closes a frame.
        write_geometry(16'd0, 16'd0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'h80, 8'h40, 8'h20);
        drain_pixels();

        // Width written with bits above the field set, then shrunk mid-row so the
        // column already lies past the new end, then height shrunk mid-frame.
        write_geometry(16'hF806, 16'd3);
        send_pixel(8'h10, 8'h20, 8'h30);
        send_pixel(8'h18, 8'h28, 8'h38);
        send_pixel(8'h20, 8'h30, 8'h40);
        send_pixel(8'h28, 8'h38, 8'h48);
        drain_pixels();
        write_reg(REG_FRAME_WIDTH, 16'd3, 1'b0);
        send_pixel(8'h30, 8'h40, 8'h50);
        send_pixel(8'h38, 8'h48, 8'h58);
        drain_pixels();
        write_reg(REG_FRAME_HEIGHT, 16'd1, 1'b0);
        send_pixel(8'h40, 8'h50, 8'h60);
        send_pixel(8'h48, 8'h58, 8'h68);
        drain_pixels();

        // Largest nominal geometry.
        write_geometry(16'd1920, 16'd65535);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        drain_pixels();

        // Random phases over each idling pattern, mostly small frames.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(49, 0);
                2: set_idling(0, 49);
                default: set_idling(27, 27);
            endcase
            pick = $urandom_range(0, 9);
            w = (pick == 0) ? 0 : (pick == 1) ? 1920 : (pick == 2) ? WIDE_WIDTH :
                $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            h = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 6);
            write_geometry(CFG_DATA_W'(w), CFG_DATA_W'(h));
            style = $urandom_range(STYLE_NOISE, STYLE_RAILS);
            case ($urandom_range(0, 2))
                0:       amp = 3;
                1:       amp = 15;
                default: amp = 40;
            endcase
            base = $urandom_range(0, 255 - amp);
            if (ph == 0)
                -> pressure_kick;
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                next_pixel(style, base, amp, c0, c1, c2);
                send_pixel(c0, c1, c2);
            end
            drain_pixels();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_total == 0 && beats_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
